// ----- sv/prodq_pkg.sv -----
`timescale 1ns / 1ps

package prodq_pkg;

    // Store depth and the widths that follow from it.
    localparam int DEPTH  = 16;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;

    // Fixed field widths of the stream payloads.
    localparam int OPC_W    = 3;
    localparam int CODE_W   = 16;
    localparam int QTY_W    = 16;
    localparam int PRICE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 4;
    localparam int ENTRY_W  = 5;
    localparam int IN_W     = 64;
    localparam int OUT_W    = 64;
    localparam int OUT_PAD  = OUT_W - (QTY_W + PRICE_W + POS_W + ENTRY_W);

    typedef enum logic [OPC_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_SEARCH     = 3'd4
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   quantity;
        logic [CODE_W-1:0]  code;
    } t_rec;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_rec              wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        t_status            status;
        logic [QTY_W-1:0]   quantity;
        logic [PRICE_W-1:0] price;
        logic [POS_W-1:0]   position;
        logic [ENTRY_W-1:0] entry_count;
    } t_result;

    // Reduce a slot sum that is known to stay below twice the depth.
    function automatic logic [ADDR_W-1:0] wrap_slot(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] d;
        d = s - SUM_W'(DEPTH);
        if (s >= SUM_W'(DEPTH)) begin
            return d[ADDR_W-1:0];
        end
        return s[ADDR_W-1:0];
    endfunction

endpackage

// ----- sv/product_deque_with_key_search_unit.sv -----
`timescale 1ns / 1ps
// Channel   | Direction | tdata (low bit first)                       | tuser
// s_axis    | in        | product_code, quantity, price_bits          | opcode
// m_axis    | out       | found_quantity, found_price_bits,           | status
//           |           | found_position, entry_count, zero pad       |
//
// One item is worked on at a time. A push, a pop, a spare opcode or a search of
// an empty list passes from the sequencer's result register into the output
// register; a search reads one stored record per cycle through the single read
// port of the record memory and ends at the first match or after the last entry.
// Reset is synchronous and active low; it empties the list, while the record
// memory keeps whatever it holds. A stalled output holds its result in the
// output register, and the next item is taken as soon as that result has moved
// into the output register.

module product_deque_with_key_search_unit
    import prodq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [IN_W-1:0]     s_axis_tdata,   // product_code, quantity, price_bits
    input  logic [OPC_W-1:0]    s_axis_tuser,   // opcode
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [OUT_W-1:0]    m_axis_tdata,   // found_quantity, found_price_bits,
                                                // found_position, entry_count, pad
    output logic [STATUS_W-1:0] m_axis_tuser    // status
);

    t_mem_req w_mem;
    t_rec     w_rd_rec;
    logic     w_res_valid;
    logic     w_res_ready;
    t_result  w_res;

    logic     r_out_valid;
    t_result  r_out;

    // The sequencer owns the list pointers and runs the search compare.
    prodq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_opcode    (t_opcode'(s_axis_tuser)),
        .i_code      (s_axis_tdata[CODE_W-1:0]),
        .i_quantity  (s_axis_tdata[CODE_W+QTY_W-1:CODE_W]),
        .i_price     (s_axis_tdata[CODE_W+QTY_W+PRICE_W-1:CODE_W+QTY_W]),
        .o_mem       (w_mem),
        .i_rd_rec    (w_rd_rec),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    // Circular record memory: one write and one registered read per cycle.
    prodq_store u_store (
        .i_clk    (i_clk),
        .i_mem    (w_mem),
        .o_rd_rec (w_rd_rec)
    );

    // Output register: a new result loads when the register is empty or its
    // current transfer completes in this cycle.
    assign w_res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = {{OUT_PAD{1'b0}}, r_out.entry_count, r_out.position,
                            r_out.price, r_out.quantity};

endmodule

// ----- sv/prodq_store.sv -----
`timescale 1ns / 1ps

module prodq_store
    import prodq_pkg::*;
(
    input  logic     i_clk,
    input  t_mem_req i_mem,
    output t_rec     o_rd_rec
);

    t_rec r_mem [DEPTH];
    t_rec r_rd_rec;

    always_ff @(posedge i_clk) begin
        if (i_mem.we) begin
            r_mem[i_mem.waddr] <= i_mem.wdata;
        end
        r_rd_rec <= r_mem[i_mem.raddr];
    end

    assign o_rd_rec = r_rd_rec;

endmodule

// ----- sv/prodq_ctrl.sv -----
`timescale 1ns / 1ps

module prodq_ctrl
    import prodq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_opcode            i_opcode,
    input  logic [CODE_W-1:0]  i_code,
    input  logic [QTY_W-1:0]   i_quantity,
    input  logic [PRICE_W-1:0] i_price,
    output t_mem_req           o_mem,
    input  t_rec               i_rd_rec,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output t_result            o_res
);

    t_state             r_state, n_state;
    logic [ADDR_W-1:0]  r_front, n_front;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CODE_W-1:0]  r_key, n_key;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic               r_cmp_v, n_cmp_v;
    logic [CNT_W-1:0]   r_cmp_pos, n_cmp_pos;
    t_result            r_res, n_res;

    logic               w_accept;
    logic               w_search_done;
    logic [ADDR_W-1:0]  w_front_dec;
    t_mem_req           w_mem;

    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_front_dec = (r_front == '0) ? ADDR_W'(DEPTH - 1) : r_front - 1'b1;

    // Datapath: list pointers, memory requests and the one-entry-per-cycle compare.
    always_comb begin
        n_front       = r_front;
        n_count       = r_count;
        n_key         = r_key;
        n_idx         = r_idx;
        n_cmp_v       = 1'b0;
        n_cmp_pos     = r_cmp_pos;
        n_res         = r_res;
        w_search_done = 1'b0;
        w_mem.we      = 1'b0;
        w_mem.waddr   = w_front_dec;
        w_mem.wdata   = '{price: i_price, quantity: i_quantity, code: i_code};
        w_mem.raddr   = wrap_slot(SUM_W'(r_front) + SUM_W'(r_idx));

        if (w_accept) begin
            n_key        = i_code;
            n_idx        = '0;
            n_res        = '0;
            n_res.status = ST_OK;
            case (i_opcode)
                OP_PUSH_FRONT: begin
                    if (r_count == CNT_W'(DEPTH)) begin
                        n_res.status = ST_FULL;
                    end else begin
                        w_mem.we    = 1'b1;
                        w_mem.waddr = w_front_dec;
                        n_front     = w_front_dec;
                        n_count     = r_count + 1'b1;
                    end
                end
                OP_PUSH_BACK: begin
                    if (r_count == CNT_W'(DEPTH)) begin
                        n_res.status = ST_FULL;
                    end else begin
                        w_mem.we    = 1'b1;
                        w_mem.waddr = wrap_slot(SUM_W'(r_front) + SUM_W'(r_count));
                        n_count     = r_count + 1'b1;
                    end
                end
                OP_POP_FRONT: begin
                    if (r_count == '0) begin
                        n_res.status = ST_EMPTY;
                    end else begin
                        n_front = wrap_slot(SUM_W'(r_front) + SUM_W'(1));
                        n_count = r_count - 1'b1;
                    end
                end
                OP_POP_BACK: begin
                    if (r_count == '0) begin
                        n_res.status = ST_EMPTY;
                    end else begin
                        n_count = r_count - 1'b1;
                    end
                end
                OP_SEARCH: begin
                    if (r_count == '0) begin
                        n_res.status = ST_NOT_FOUND;
                    end
                end
                default: begin
                end
            endcase
            n_res.entry_count = ENTRY_W'(n_count);
        end else if (r_state == S_SEARCH) begin
            // Issue the read of the next entry while the previous one is compared.
            if (r_idx != r_count) begin
                n_idx     = r_idx + 1'b1;
                n_cmp_v   = 1'b1;
                n_cmp_pos = r_idx;
            end
            if (r_cmp_v) begin
                if (i_rd_rec.code == r_key) begin
                    w_search_done  = 1'b1;
                    n_res.status   = ST_OK;
                    n_res.quantity = i_rd_rec.quantity;
                    n_res.price    = i_rd_rec.price;
                    n_res.position = POS_W'(r_cmp_pos);
                end else if (r_cmp_pos == r_count - 1'b1) begin
                    w_search_done = 1'b1;
                    n_res.status  = ST_NOT_FOUND;
                end
            end
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if ((i_opcode == OP_SEARCH) && (r_count != '0)) begin
                        n_state = S_SEARCH;
                    end else begin
                        n_state = S_RESULT;
                    end
                end
            end
            S_SEARCH: begin
                if (w_search_done) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        o_in_ready  = (r_state == S_IDLE);
        o_res_valid = (r_state == S_RESULT);
        o_res       = r_res;
        o_mem       = w_mem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_front <= '0;
            r_count <= '0;
            r_cmp_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_count <= n_count;
            r_cmp_v <= n_cmp_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_idx     <= n_idx;
        r_cmp_pos <= n_cmp_pos;
        r_res     <= n_res;
    end

endmodule

// ----- sv/prodq_checker.sv -----
`timescale 1ns / 1ps

module prodq_checker
    import prodq_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic [IN_W-1:0]     s_axis_tdata,
    input logic [OPC_W-1:0]    s_axis_tuser,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [OUT_W-1:0]    m_axis_tdata,
    input logic [STATUS_W-1:0] m_axis_tuser
);

    logic [QTY_W-1:0]   w_qty;
    logic [PRICE_W-1:0] w_price;
    logic [POS_W-1:0]   w_pos;
    logic [ENTRY_W-1:0] w_count;
    logic               w_in_xfer;

    assign w_qty     = m_axis_tdata[QTY_W-1:0];
    assign w_price   = m_axis_tdata[QTY_W+PRICE_W-1:QTY_W];
    assign w_pos     = m_axis_tdata[QTY_W+PRICE_W+POS_W-1:QTY_W+PRICE_W];
    assign w_count   = m_axis_tdata[QTY_W+PRICE_W+POS_W+ENTRY_W-1:QTY_W+PRICE_W+POS_W];
    assign w_in_xfer = s_axis_tvalid && s_axis_tready;

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output payload changed while stalled");

    // Only one item is in work: the input closes right after a transfer.
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> !s_axis_tready)
        else $error("input accepted a second item while busy");

    // The reported fill never exceeds the store depth.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_count <= ENTRY_W'(DEPTH)))
        else $error("entry count beyond depth");

    // Full and empty flags agree with the reported fill.
    a_full_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            ((m_axis_tuser != ST_FULL) || (w_count == ENTRY_W'(DEPTH))) &&
            ((m_axis_tuser != ST_EMPTY) || (w_count == '0)))
        else $error("full or empty status disagrees with entry count");

    // Match fields are zero on any status other than a hit or plain done.
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_OK) |->
            (w_qty == '0) && (w_price == '0) && (w_pos == '0))
        else $error("match fields not cleared on a failed operation");

endmodule

bind product_deque_with_key_search_unit prodq_checker u_prodq_checker (.*);
